[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/edsp_pkg.sv]
// Shared types and constants of the DER signature parser.
`timescale 1ns / 1ps

package edsp_pkg;

	localparam int unsigned VAL_W = 256;

	// secp256k1 group order and half of it (rounded down).
	localparam logic [VAL_W-1:0] ORDER_N =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
	localparam logic [VAL_W-1:0] HALF_N =
		256'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF5D576E7357A4501DDFE92F46681B20A0;

	localparam logic [7:0] TAG_SEQ = 8'h30;
	localparam logic [7:0] TAG_INT = 8'h02;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_SHORT     = 3'd1;
	localparam logic [2:0] STAT_SEQ_TAG   = 3'd2;
	localparam logic [2:0] STAT_SEQ_OVER  = 3'd3;
	localparam logic [2:0] STAT_INT_TAG   = 3'd4;
	localparam logic [2:0] STAT_INT_OVER  = 3'd5;
	localparam logic [2:0] STAT_INT_LONG  = 3'd6;

	localparam logic [6:0] RES_PER_SIG = 7'd64;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] r;
		logic [VAL_W-1:0] s;
	} frame_t;

	typedef struct packed {
		logic             flipped;
		logic [VAL_W-1:0] value;
	} lows_t;

endpackage

[rtl/core/ecdsa_der_signature_parser_low_s.sv]
// Top level of the DER ECDSA signature parser with low-S normalization.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    sig_byte, sig_end
//  out       output     out_valid / out_ready  value_byte, status, s_flipped, final_res
//  cfg       input      cfg_valid / cfg_ready  low_s_enable
//
// The parser state advances on each accepted byte. The final byte is captured into a frame
// register; its load into the output shift register waits while the output is busy and runs
// the 256-bit low-S compare and subtract. A valid signature then leaves as 64 words, one per
// cycle while out_ready is high; an invalid one as one status word.
// While a frame waits for the output register, further bytes are taken, but a final byte waits.
// Reset clears all control state and sets low_s_enable to 1; there is no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecdsa_der_signature_parser_low_s (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] sig_byte,
	input  logic       sig_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] value_byte,
	output logic [2:0] status,
	output logic       s_flipped,
	output logic       final_res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       low_s_enable
);
	import edsp_pkg::*;

	logic   low_s_en_q;
	logic   frame_valid_s1;
	frame_t frame_s1;
	logic   frame_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_s_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			low_s_en_q <= low_s_enable;
		end
	end

	edsp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sig_byte       (sig_byte),
		.sig_end        (sig_end),
		.frame_take     (frame_take),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	edsp_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.low_s_en       (low_s_en_q),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.frame_take     (frame_take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value_byte     (value_byte),
		.status         (status),
		.s_flipped      (s_flipped),
		.final_res      (final_res)
	);

	// An error word is a single zero word that ends its run.
	`ASSERT_IMPL(a_err_word, clk, arst_n, out_valid && status != STAT_OK, value_byte == 8'h00 && final_res && !s_flipped)
	// Only a valid signature produces more than one word.
	`ASSERT_IMPL(a_multi_ok, clk, arst_n, out_valid && !final_res, status == STAT_OK)
	// With no frame waiting, the output goes empty after the last word of a run.
	`ASSERT_NEXT(a_drain, clk, arst_n, out_valid && out_ready && final_res && !frame_valid_s1, !out_valid)

endmodule

[rtl/core/edsp_parser.sv]
// Byte-wise DER parser: tracks the SEQUENCE and INTEGER fields and captures a frame.
`timescale 1ns / 1ps

module edsp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     sig_byte,
	input  logic           sig_end,
	input  logic           frame_take,
	output logic           frame_valid_s1,
	output edsp_pkg::frame_t frame_s1
);
	import edsp_pkg::*;

	localparam logic [2:0] PH_SEQ_TAG = 3'd0;
	localparam logic [2:0] PH_SEQ_LEN = 3'd1;
	localparam logic [2:0] PH_INT_TAG = 3'd2;
	localparam logic [2:0] PH_INT_LEN = 3'd3;
	localparam logic [2:0] PH_VALUE   = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;
	localparam logic [2:0] PH_HALT    = 3'd6;

	logic [2:0]       phase_q, phase_n;
	logic [8:0]       bytes_q, bytes_n;
	logic [7:0]       seq_len_q, seq_len_n;
	logic [7:0]       seq_left_q, seq_left_n;
	logic [5:0]       int_left_q, int_left_n;
	logic             which_q, which_n;
	logic [2:0]       err_q, err_n;
	logic [VAL_W-1:0] r_q, r_n;
	logic [VAL_W-1:0] s_q, s_n;
	logic [7:0]       left_dec;
	logic [2:0]       status_n;
	logic             accept;

	assign in_ready = !sig_end || !frame_valid_s1;
	assign accept = in_valid && in_ready;
	assign left_dec = seq_left_q - 8'd1;

	always_comb begin
		phase_n    = phase_q;
		seq_len_n  = seq_len_q;
		seq_left_n = seq_left_q;
		int_left_n = int_left_q;
		which_n    = which_q;
		err_n      = err_q;
		r_n        = r_q;
		s_n        = s_q;
		bytes_n    = (bytes_q == 9'd511) ? bytes_q : bytes_q + 9'd1;
		unique case (phase_q)
			PH_SEQ_TAG: begin
				if (sig_byte != TAG_SEQ) begin
					err_n   = STAT_SEQ_TAG;
					phase_n = PH_HALT;
				end else begin
					phase_n = PH_SEQ_LEN;
				end
			end
			PH_SEQ_LEN: begin
				seq_len_n  = sig_byte;
				seq_left_n = sig_byte;
				phase_n    = PH_INT_TAG;
			end
			PH_INT_TAG: begin
				if (seq_left_q != 8'd0) begin
					seq_left_n = left_dec;
					if (sig_byte != TAG_INT) begin
						err_n   = STAT_INT_TAG;
						phase_n = PH_HALT;
					end else begin
						phase_n = PH_INT_LEN;
					end
				end
			end
			PH_INT_LEN: begin
				if (seq_left_q != 8'd0) begin
					seq_left_n = left_dec;
					priority if (sig_byte > left_dec) begin
						err_n   = STAT_INT_OVER;
						phase_n = PH_HALT;
					end else if (sig_byte > 8'd33) begin
						err_n   = STAT_INT_LONG;
						phase_n = PH_HALT;
					end else if (sig_byte == 8'd0) begin
						which_n = 1'b1;
						phase_n = which_q ? PH_DONE : PH_INT_TAG;
					end else begin
						int_left_n = sig_byte[5:0];
						phase_n    = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				priority if (seq_left_q == 8'd0 || int_left_q == 6'd0) begin
					err_n   = STAT_INT_TAG;
					phase_n = PH_HALT;
				end else if (int_left_q == 6'd33 && sig_byte != 8'd0) begin
					err_n   = STAT_INT_LONG;
					phase_n = PH_HALT;
				end else begin
					seq_left_n = left_dec;
					int_left_n = int_left_q - 6'd1;
					if (which_q) begin
						s_n = {s_q[VAL_W-9:0], sig_byte};
					end else begin
						r_n = {r_q[VAL_W-9:0], sig_byte};
					end
					if (int_left_q == 6'd1) begin
						which_n = 1'b1;
						phase_n = which_q ? PH_DONE : PH_INT_TAG;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Checks in priority order, all on the state after this byte.
	always_comb begin
		priority if (bytes_n < 9'd8) begin
			status_n = STAT_SHORT;
		end else if (err_n == STAT_SEQ_TAG) begin
			status_n = STAT_SEQ_TAG;
		end else if ({2'b00, seq_len_n} + 10'd2 > {1'b0, bytes_n}) begin
			status_n = STAT_SEQ_OVER;
		end else if (err_n != STAT_OK) begin
			status_n = err_n;
		end else if (phase_n != PH_DONE) begin
			status_n = STAT_INT_TAG;
		end else begin
			status_n = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SEQ_TAG;
			bytes_q        <= '0;
			seq_len_q      <= '0;
			seq_left_q     <= '0;
			int_left_q     <= '0;
			which_q        <= 1'b0;
			err_q          <= STAT_OK;
			r_q            <= '0;
			s_q            <= '0;
			frame_valid_s1 <= 1'b0;
		end else begin
			if (frame_take) begin
				frame_valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (sig_end) begin
					frame_valid_s1 <= 1'b1;
					phase_q        <= PH_SEQ_TAG;
					bytes_q        <= '0;
					seq_len_q      <= '0;
					seq_left_q     <= '0;
					int_left_q     <= '0;
					which_q        <= 1'b0;
					err_q          <= STAT_OK;
					r_q            <= '0;
					s_q            <= '0;
				end else begin
					phase_q    <= phase_n;
					bytes_q    <= bytes_n;
					seq_len_q  <= seq_len_n;
					seq_left_q <= seq_left_n;
					int_left_q <= int_left_n;
					which_q    <= which_n;
					err_q      <= err_n;
					r_q        <= r_n;
					s_q        <= s_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && sig_end) begin
			frame_s1.status <= status_n;
			frame_s1.r      <= r_n;
			frame_s1.s      <= s_n;
		end
	end

endmodule

[rtl/core/edsp_lows.sv]
// Low-S normalization, if enabled: s above half the group order becomes |n - s|.
`timescale 1ns / 1ps

module edsp_lows (
	input  logic                     enable,
	input  logic [edsp_pkg::VAL_W-1:0] s,
	output edsp_pkg::lows_t          res
);
	import edsp_pkg::*;

	logic [VAL_W:0] half_minus_s;
	logic [VAL_W:0] n_minus_s;
	logic [VAL_W:0] s_minus_n;
	logic           above_half;
	logic           above_n;

	// A borrow out of the top bit means s is the larger operand.
	assign half_minus_s = {1'b0, HALF_N} - {1'b0, s};
	assign n_minus_s    = {1'b0, ORDER_N} - {1'b0, s};
	assign s_minus_n    = {1'b0, s} - {1'b0, ORDER_N};
	assign above_half   = half_minus_s[VAL_W];
	assign above_n      = n_minus_s[VAL_W];

	always_comb begin
		res.flipped = enable && above_half;
		if (!res.flipped) begin
			res.value = s;
		end else if (above_n) begin
			res.value = s_minus_n[VAL_W-1:0];
		end else begin
			res.value = n_minus_s[VAL_W-1:0];
		end
	end

endmodule

[rtl/core/edsp_emit.sv]
// Result register: loads a frame and shifts out the compact signature or a status word.
`timescale 1ns / 1ps

module edsp_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             low_s_en,
	input  logic             frame_valid_s1,
	input  edsp_pkg::frame_t frame_s1,
	output logic             frame_take,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       value_byte,
	output logic [2:0]       status,
	output logic             s_flipped,
	output logic             final_res
);
	import edsp_pkg::*;

	lows_t              lows;
	logic [2*VAL_W-1:0] data_q;
	logic [6:0]         left_q;
	logic [2:0]         status_q;
	logic               flip_q;
	logic               out_acc;

	edsp_lows u_lows (
		.enable (low_s_en),
		.s      (frame_s1.s),
		.res    (lows)
	);

	assign out_valid  = (left_q != 7'd0);
	assign out_acc    = out_valid && out_ready;
	assign value_byte = data_q[2*VAL_W-1 -: 8];
	assign status     = status_q;
	assign s_flipped  = flip_q;
	assign final_res  = (left_q == 7'd1);

	// A new frame may load in the same cycle as the last word of the previous one leaves.
	assign frame_take = frame_valid_s1 && (!out_valid || (final_res && out_ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (frame_take) begin
			left_q <= (frame_s1.status == STAT_OK) ? RES_PER_SIG : 7'd1;
		end else if (out_acc) begin
			left_q <= left_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			if (frame_s1.status == STAT_OK) begin
				data_q   <= {frame_s1.r, lows.value};
				flip_q   <= lows.flipped;
			end else begin
				data_q   <= '0;
				flip_q   <= 1'b0;
			end
			status_q <= frame_s1.status;
		end else if (out_acc) begin
			data_q <= {data_q[2*VAL_W-9:0], 8'h00};
		end
	end

endmodule

[tb/ecdsa_der_signature_parser_low_s_tb.sv]
// Self-checking testbench for the DER signature parser with low-S normalization.
`timescale 1ns / 1ps

module ecdsa_der_signature_parser_low_s_tb;
	import edsp_pkg::*;

	localparam int MIN_SIG_BYTES = 8;
	localparam int MAX_INT_LEN   = 33;
	localparam int COUNT_MAX     = 511;
	localparam int WORDS_PER_SIG = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;

	// secp256k1 group order and half of it, rounded down.
	localparam logic [255:0] ORDER_V =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
	localparam logic [255:0] HALF_V = ORDER_V >> 1;

	typedef enum logic [2:0] {
		P_SEQ_TAG, P_SEQ_LEN, P_INT_TAG, P_INT_LEN, P_VALUE, P_DONE, P_HALT
	} parse_e;

	typedef enum int {
		BODY_EMPTY, BODY_SMALL, BODY_FULL, BODY_PADDED, BODY_SPECIAL, BODY_OVERLONG, BODY_BADPAD
	} body_e;

	typedef struct packed {
		logic [7:0] value;
		logic [2:0] code;
		logic       flipped;
		logic       last;
	} out_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] sig_byte;
	logic       sig_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] value_byte;
	logic [2:0] status;
	logic       s_flipped;
	logic       final_res;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       low_s_enable;

	// Predicted parser state.
	parse_e       parse_at;
	logic [8:0]   byte_count;
	logic [7:0]   seq_len;
	logic [7:0]   seq_room;
	logic [7:0]   int_room;
	logic         on_s;
	logic [2:0]   first_fault;
	logic [255:0] r_acc;
	logic [255:0] s_acc;
	logic         lows_on;

	out_word_t  due_words[$];
	out_word_t  head_word;
	logic [7:0] der_bytes[$];
	logic [7:0] int_body[$];
	logic [7:0] r_body[$];
	logic [7:0] s_body[$];

	int mismatch_count;
	int items_sent;
	int hold_req;
	int stall_left;
	bit send_quiet;
	bit recv_quiet;

	ecdsa_der_signature_parser_low_s dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sig_byte    (sig_byte),
		.sig_end     (sig_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value_byte  (value_byte),
		.status      (status),
		.s_flipped   (s_flipped),
		.final_res   (final_res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.low_s_enable(low_s_enable)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic clear_parse;
		parse_at = P_SEQ_TAG;
		byte_count = '0;
		seq_len = '0;
		seq_room = '0;
		int_room = '0;
		on_s = 1'b0;
		first_fault = STAT_OK;
		r_acc = '0;
		s_acc = '0;
	endtask

	task automatic stop_parse(input logic [2:0] code);
		first_fault = code;
		parse_at = P_HALT;
	endtask

	task automatic close_int;
		if (!on_s) begin
			on_s = 1'b1;
			parse_at = P_INT_TAG;
		end else begin
			parse_at = P_DONE;
		end
	endtask

	// Advances the predicted parser by one byte and queues the words a final byte causes.
	task automatic decode_byte(input logic [7:0] b, input logic last);
		out_word_t    w;
		logic [2:0]   st;
		logic         flip;
		logic [255:0] s_out;
		int           k;
		case (parse_at)
			P_SEQ_TAG: begin
				if (b != TAG_SEQ) stop_parse(STAT_SEQ_TAG);
				else parse_at = P_SEQ_LEN;
			end
			P_SEQ_LEN: begin
				seq_len = b;
				seq_room = b;
				parse_at = P_INT_TAG;
			end
			P_INT_TAG: begin
				if (seq_room != 0) begin
					seq_room--;
					if (b != TAG_INT) stop_parse(STAT_INT_TAG);
					else parse_at = P_INT_LEN;
				end
			end
			P_INT_LEN: begin
				if (seq_room != 0) begin
					seq_room--;
					if (b > seq_room) stop_parse(STAT_INT_OVER);
					else if (b > 8'(MAX_INT_LEN)) stop_parse(STAT_INT_LONG);
					else if (b == 0) close_int();
					else begin
						int_room = b;
						parse_at = P_VALUE;
					end
				end
			end
			P_VALUE: begin
				if (seq_room == 0 || int_room == 0) stop_parse(STAT_INT_TAG);
				else if (int_room == 8'(MAX_INT_LEN) && b != 0) stop_parse(STAT_INT_LONG);
				else begin
					seq_room--;
					int_room--;
					if (on_s) s_acc = {s_acc[247:0], b};
					else r_acc = {r_acc[247:0], b};
					if (int_room == 0) close_int();
				end
			end
			default: ;
		endcase
		if (byte_count != 9'(COUNT_MAX)) byte_count++;

		if (last) begin
			st = STAT_OK;
			if (byte_count < 9'(MIN_SIG_BYTES)) st = STAT_SHORT;
			else if (first_fault == STAT_SEQ_TAG) st = STAT_SEQ_TAG;
			else if ({2'b00, seq_len} + 10'd2 > {1'b0, byte_count}) st = STAT_SEQ_OVER;
			else if (first_fault != STAT_OK) st = first_fault;
			else if (parse_at != P_DONE) st = STAT_INT_TAG;

			if (st != STAT_OK) begin
				w.value = 8'h00;
				w.code = st;
				w.flipped = 1'b0;
				w.last = 1'b1;
				due_words = {due_words, w};
			end else begin
				flip = lows_on && (s_acc > HALF_V);
				s_out = s_acc;
				// Above the order the flip yields the magnitude of the difference.
				if (flip) s_out = (s_acc > ORDER_V) ? s_acc - ORDER_V : ORDER_V - s_acc;
				for (k = 0; k < WORDS_PER_SIG; k++) begin
					w.value = (k < 32) ? r_acc[255 - 8 * k -: 8] : s_out[255 - 8 * (k - 32) -: 8];
					w.code = STAT_OK;
					w.flipped = flip;
					w.last = (k == WORDS_PER_SIG - 1);
					due_words = {due_words, w};
				end
			end
			clear_parse();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				$display("%0t: word with nothing expected, value_byte %02h status %0d",
					$time, value_byte, status);
				mismatch_count++;
			end else begin
				head_word = due_words.pop_front();
				if (value_byte !== head_word.value) begin
					$display("%0t: value_byte expected %02h actual %02h",
						$time, head_word.value, value_byte);
					mismatch_count++;
				end
				if (status !== head_word.code) begin
					$display("%0t: status expected %0d actual %0d",
						$time, head_word.code, status);
					mismatch_count++;
				end
				if (s_flipped !== head_word.flipped) begin
					$display("%0t: s_flipped expected %0b actual %0b",
						$time, head_word.flipped, s_flipped);
					mismatch_count++;
				end
				if (final_res !== head_word.last) begin
					$display("%0t: final_res expected %0b actual %0b",
						$time, head_word.last, final_res);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold when a test asks for it.
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!recv_quiet && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Offers one byte and returns at the edge where it is taken, with valid still high.
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (!send_quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1'b1;
		sig_byte = b;
		sig_end = last;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, last);
		items_sent++;
	endtask

	task automatic send_der;
		int i;
		for (i = 0; i < der_bytes.size(); i++) send_byte(der_bytes[i], i == der_bytes.size() - 1);
		der_bytes.delete();
	endtask

	task automatic wait_drain;
		@(negedge clk);
		in_valid = 1'b0;
		while (due_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_low_s(input logic v);
		wait_drain();
		cfg_valid = 1'b1;
		low_s_enable = v;
		do @(posedge clk); while (!cfg_ready);
		lows_on = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic fill_body(input body_e mode);
		logic [255:0] pick;
		int           i;
		int_body.delete();
		case (mode)
			BODY_SMALL: repeat ($urandom_range(1, 4)) int_body = {int_body, 8'($urandom)};
			BODY_FULL: repeat (32) int_body = {int_body, 8'($urandom)};
			BODY_PADDED: begin
				int_body = {int_body, 8'h00};
				repeat (32) int_body = {int_body, 8'($urandom)};
			end
			BODY_SPECIAL: begin
				case ($urandom_range(0, 6))
					0: pick = HALF_V;
					1: pick = HALF_V + 1;
					2: pick = HALF_V - 1;
					3: pick = ORDER_V - 1;
					4: pick = ORDER_V;
					5: pick = ORDER_V + 1;
					default: pick = '1;
				endcase
				if ($urandom_range(0, 1)) int_body = {int_body, 8'h00};
				for (i = 0; i < 32; i++) int_body = {int_body, pick[255 - 8 * i -: 8]};
			end
			BODY_OVERLONG: repeat ($urandom_range(34, 36)) int_body = {int_body, 8'($urandom)};
			BODY_BADPAD: begin
				int_body = {int_body, 8'($urandom_range(1, 255))};
				repeat (32) int_body = {int_body, 8'($urandom)};
			end
			default: ;
		endcase
	endtask

	// Assembles SEQUENCE { INTEGER r, INTEGER s }, then filler inside and beyond the sequence.
	task automatic build_sig(input body_e rm, input body_e sm, input int extra_in, input int tail);
		int i;
		fill_body(rm);
		r_body = int_body;
		fill_body(sm);
		s_body = int_body;
		der_bytes.delete();
		der_bytes = {der_bytes, TAG_SEQ};
		der_bytes = {der_bytes, 8'(4 + r_body.size() + s_body.size() + extra_in)};
		der_bytes = {der_bytes, TAG_INT};
		der_bytes = {der_bytes, 8'(r_body.size())};
		for (i = 0; i < r_body.size(); i++) der_bytes = {der_bytes, r_body[i]};
		der_bytes = {der_bytes, TAG_INT};
		der_bytes = {der_bytes, 8'(s_body.size())};
		for (i = 0; i < s_body.size(); i++) der_bytes = {der_bytes, s_body[i]};
		repeat (extra_in + tail) der_bytes = {der_bytes, 8'($urandom)};
	endtask

	function automatic body_e pick_r_body();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return BODY_SMALL;
			4, 5, 6: return BODY_FULL;
			7, 8: return BODY_PADDED;
			default: return BODY_EMPTY;
		endcase
	endfunction

	function automatic body_e pick_s_body();
		case ($urandom_range(0, 9))
			0, 1, 2: return BODY_SMALL;
			3, 4, 5: return BODY_FULL;
			6: return BODY_PADDED;
			7, 8: return BODY_SPECIAL;
			default: return BODY_EMPTY;
		endcase
	endfunction

	task automatic corrupt_der;
		int idx;
		int cut;
		case ($urandom_range(0, 2))
			0: begin
				idx = $urandom_range(0, der_bytes.size() - 1);
				der_bytes[idx] = 8'($urandom);
			end
			1: begin
				cut = $urandom_range(1, der_bytes.size() - 1);
				repeat (cut) void'(der_bytes.pop_back());
			end
			default: der_bytes[1] = 8'($urandom);
		endcase
	endtask

	// Mostly well-formed signatures with random content; the rest broken or plain noise.
	task automatic random_signature;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			build_sig(pick_r_body(), pick_s_body(),
				($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0,
				($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
		end else if (roll < 75) begin
			if ($urandom_range(0, 1))
				build_sig($urandom_range(0, 1) ? BODY_OVERLONG : BODY_BADPAD, pick_s_body(), 0, 0);
			else
				build_sig(pick_r_body(), $urandom_range(0, 1) ? BODY_OVERLONG : BODY_BADPAD, 0, 0);
		end else if (roll < 88) begin
			build_sig(pick_r_body(), pick_s_body(), 0, 0);
			corrupt_der();
		end else begin
			der_bytes.delete();
			repeat ($urandom_range(1, 20)) der_bytes = {der_bytes, 8'($urandom)};
		end
		send_der();
	endtask

	task automatic send_random_signatures(input int n);
		int start;
		start = items_sent;
		while (items_sent - start < n) random_signature();
	endtask

	task automatic test_directed_basics;
		// A lone tag byte is too short, whatever it holds.
		der_bytes = '{TAG_SEQ};
		send_der();
		der_bytes = '{TAG_SEQ ^ 8'h01, 8'h06, TAG_INT, 8'h01, 8'h01, TAG_INT, 8'h01, 8'h01};
		send_der();
		// Smallest valid signature, with the extreme byte values as r and s.
		der_bytes = '{TAG_SEQ, 8'h06, TAG_INT, 8'h01, 8'hFF, TAG_INT, 8'h01, 8'h00};
		send_der();
		der_bytes = '{TAG_SEQ, 8'h07, TAG_INT, 8'h01, 8'h01, TAG_INT, 8'h01, 8'h80};
		send_der();
	endtask

	task automatic test_error_codes;
		der_bytes = '{TAG_SEQ, 8'h06, TAG_INT ^ 8'($urandom_range(1, 255)), 8'h01,
			8'($urandom), TAG_INT, 8'h01, 8'($urandom)};
		send_der();
		// The sequence closes after r, so s is never complete.
		der_bytes = '{TAG_SEQ, 8'h03, TAG_INT, 8'h01, 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom)};
		send_der();
		der_bytes = '{TAG_SEQ, 8'h06, TAG_INT, 8'h05, 8'($urandom),
			TAG_INT, 8'h01, 8'($urandom)};
		send_der();
		build_sig(BODY_OVERLONG, BODY_SMALL, 0, 0);
		send_der();
		build_sig(BODY_SMALL, BODY_BADPAD, 0, 0);
		send_der();
		build_sig(BODY_SMALL, BODY_SMALL, 2, 3);
		send_der();
		build_sig(BODY_EMPTY, BODY_PADDED, 0, 0);
		send_der();
	endtask

	task automatic test_low_s_settings;
		write_low_s(1'b0);
		build_sig(BODY_SMALL, BODY_SPECIAL, 0, 0);
		send_der();
		send_random_signatures(10);
		write_low_s(1'b1);
		build_sig(BODY_SMALL, BODY_SPECIAL, 0, 0);
		send_der();
	endtask

	task automatic test_random_mix;
		send_random_signatures(20);
	endtask

	// The receiver holds off while the sender keeps offering, so the input has to stall.
	task automatic test_output_backpressure;
		wait_drain();
		send_quiet = 1'b1;
		hold_req = HOLD_CYCLES;
		repeat (4) begin
			build_sig(BODY_SMALL, BODY_SMALL, 0, 0);
			send_der();
		end
		send_quiet = 1'b0;
		wait_drain();
	endtask

	task automatic test_quiet_tail;
		wait_drain();
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		send_random_signatures(20);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sig_byte = 8'h00;
		sig_end = 1'b0;
		cfg_valid = 1'b0;
		low_s_enable = 1'b1;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		hold_req = 0;
		mismatch_count = 0;
		items_sent = 0;
		lows_on = 1'b1;
		clear_parse();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_basics();
		test_error_codes();
		test_low_s_settings();
		test_random_mix();
		test_output_backpressure();
		test_quiet_tail();

		wait_drain();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
